### sv/phdc_pkg.sv
// phdc_pkg: shared types and constants of the pid h-bridge duty controller
// configuration and result structs, register indexes, fixed-point constants
// no dependencies
package phdc_pkg;

  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 16;
  localparam int DUTY_W   = 7;
  localparam int TOP_W    = 16;
  localparam int DIR_W    = 2;
  localparam int TEMP_W   = 10;
  localparam int CFG_IDX_W = 3;

  localparam int ERR_W    = TEMP_W + 1;
  localparam int SUM_W    = 18;
  localparam int LAST_W   = 12;
  localparam int MUL_W    = 25;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 45;
  localparam int FRAC_BITS = 16;

  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  localparam logic [DUTY_W-1:0] DUTY_KICK = 7'd3;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  localparam logic MODE_RESTART = 1'b1;

  localparam logic [DIR_W-1:0] DIR_HEAT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_COOL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P    = 24'd131072;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I    = 24'd3277;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D    = 24'd327680;
  localparam logic [LIMIT_W-1:0] RST_INT_LIMIT = 16'd1900;
  localparam logic [DUTY_W-1:0]  RST_CEILING   = 7'd95;
  localparam logic [TOP_W-1:0]   RST_TOP       = 16'd999;
  localparam logic [DIR_W-1:0]   RST_DIRECTION = 2'd0;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] int_limit;
    logic [DUTY_W-1:0]  duty_ceiling;
    logic [TOP_W-1:0]   timer_top;
    logic [DIR_W-1:0]   direction;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [TOP_W-1:0]  heat;
    logic [TOP_W-1:0]  cool;
    logic              enable;
  } result_t;

endpackage

### sv/phdc_mul.sv
// phdc_mul: shared signed 25x25 multiplier with registered product and hold enable
// depends on phdc_pkg
module phdc_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [phdc_pkg::MUL_W-1:0]   a,
  input  logic signed [phdc_pkg::MUL_W-1:0]   b,
  output logic signed [phdc_pkg::PROD_W-1:0]  prod
);
  import phdc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

### sv/phdc_core.sv
// phdc_core: sequencer and datapath of the pid step, integral clamp and pwm scaling
// drives the shared multiplier phdc_mul; depends on phdc_pkg
module phdc_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              mode,
  input  logic [phdc_pkg::TEMP_W-1:0]       target_temp,
  input  logic [phdc_pkg::TEMP_W-1:0]       measured_temp,
  input  phdc_pkg::cfg_t                    cfg,
  input  logic                              res_ready,
  output logic                              busy,
  output logic                              done,
  output phdc_pkg::result_t                 res
);
  import phdc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MP, ST_MI, ST_MD, ST_MA, ST_LIMIT, ST_SCALE, ST_RECIP, ST_FIN
  } state_t;

  state_t state;

  logic                     mode_q;
  logic [TEMP_W-1:0]        target_q;
  logic [TEMP_W-1:0]        measured_q;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [LAST_W-1:0] last_error;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [LAST_W-1:0] d_q;
  logic signed [ACC_W-1:0]  acc;
  logic [DUTY_W-1:0]        duty_q;

  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_raw;
  logic signed [SUM_W:0]    lim;
  logic signed [SUM_W:0]    lim_neg;
  logic signed [SUM_W:0]    sum_c;
  logic signed [LAST_W-1:0] d;
  logic [ACC_W-FRAC_BITS-1:0] whole;
  logic [DUTY_W-1:0]        ceil_eff;
  logic [DUTY_W-1:0]        duty_calc;
  logic [TOP_W:0]           top_plus;
  logic [TOP_W:0]           quot;
  logic [TOP_W-1:0]         cmp;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // product holds while the finished result waits
  assign mul_en = (state != ST_FIN);

  phdc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // error, clamped integral and derivative
  always_comb begin
    err     = $signed({1'b0, target_q}) - $signed({1'b0, measured_q});
    sum_raw = {error_sum[SUM_W-1], error_sum} + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    lim     = {{(SUM_W+1-LIMIT_W){1'b0}}, cfg.int_limit};
    lim_neg = -lim;
    if (sum_raw > lim) begin
      sum_c = lim;
    end else if (sum_raw < lim_neg) begin
      sum_c = lim_neg;
    end else begin
      sum_c = sum_raw;
    end
    d = {{(LAST_W-ERR_W){err[ERR_W-1]}}, err} - last_error;
  end

  // floor and clamp to duty
  always_comb begin
    whole    = acc[ACC_W-1:FRAC_BITS];
    ceil_eff = (cfg.duty_ceiling > DUTY_FULL) ? DUTY_FULL : cfg.duty_ceiling;
    if (acc[ACC_W-1]) begin
      duty_calc = '0;
    end else if (whole > {{(ACC_W-FRAC_BITS-DUTY_W){1'b0}}, ceil_eff}) begin
      duty_calc = ceil_eff;
    end else begin
      duty_calc = whole[DUTY_W-1:0];
    end
  end

  // multiplier operand select
  always_comb begin
    top_plus = {1'b0, cfg.timer_top} + {{TOP_W{1'b0}}, 1'b1};
    unique case (state)
      ST_MP: begin
        mul_a = {1'b0, cfg.gain_p};
        mul_b = {{(MUL_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      ST_MI: begin
        mul_a = {1'b0, cfg.gain_i};
        mul_b = {{(MUL_W-SUM_W){error_sum[SUM_W-1]}}, error_sum};
      end
      ST_MD: begin
        mul_a = {1'b0, cfg.gain_d};
        mul_b = {{(MUL_W-LAST_W){d_q[LAST_W-1]}}, d_q};
      end
      ST_SCALE: begin
        mul_a = {{(MUL_W-TOP_W-1){1'b0}}, top_plus};
        mul_b = {{(MUL_W-DUTY_W){1'b0}}, duty_q};
      end
      ST_RECIP: begin
        mul_a = {1'b0, prod[RECIP_W-1:0]};
        mul_b = {1'b0, RECIP_100};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // compare value and channel routing
  always_comb begin
    quot = prod[RECIP_SHIFT+TOP_W:RECIP_SHIFT];
    cmp  = (quot > {1'b0, cfg.timer_top}) ? cfg.timer_top : quot[TOP_W-1:0];
    res.duty   = duty_q;
    res.heat   = '0;
    res.cool   = '0;
    res.enable = 1'b0;
    if (cfg.direction == DIR_HEAT) begin
      res.heat   = cmp;
      res.enable = 1'b1;
    end else if (cfg.direction == DIR_COOL) begin
      res.cool   = cmp;
      res.enable = 1'b1;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_FIN) && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            mode_q     <= mode;
            target_q   <= target_temp;
            measured_q <= measured_temp;
            state      <= ST_PREP;
          end
        end
        ST_PREP: begin
          acc <= '0;
          if (mode_q == MODE_RESTART) begin
            error_sum  <= '0;
            last_error <= '0;
            duty_q     <= DUTY_KICK;
            state      <= ST_SCALE;
          end else begin
            error_sum  <= sum_c[SUM_W-1:0];
            last_error <= {{(LAST_W-ERR_W){err[ERR_W-1]}}, err};
            err_q      <= err;
            d_q        <= d;
            state      <= ST_MP;
          end
        end
        ST_MP: begin
          state <= ST_MI;
        end
        ST_MI: begin
          acc   <= acc + prod[ACC_W-1:0];
          state <= ST_MD;
        end
        ST_MD: begin
          acc   <= acc + prod[ACC_W-1:0];
          state <= ST_MA;
        end
        ST_MA: begin
          acc   <= acc + prod[ACC_W-1:0];
          state <= ST_LIMIT;
        end
        ST_LIMIT: begin
          duty_q <= duty_calc;
          state  <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_RECIP;
        end
        ST_RECIP: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE)
    else $error("start while sequencer busy");

  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP && mode_q == MODE_RESTART) |=>
      (error_sum == '0 && last_error == '0 && state == ST_SCALE))
    else $error("restart did not clear integral state");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCALE |-> duty_q <= DUTY_FULL)
    else $error("duty above full scale");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !res_ready) |=> state == ST_FIN)
    else $error("result dropped while output full");

endmodule

### sv/pid_hbridge_duty_controller_unit.sv
// pid_hbridge_duty_controller_unit: top level, configuration registers and result register
// instantiates phdc_core; depends on phdc_pkg
//
// usage:
//   item channel (item_valid/item_stall) takes mode, target_temp, measured_temp.
//   result channel (result_valid/result_stall) gives duty_pct, heat_compare,
//   cool_compare, bridge_enable; one result beat per item beat.
//   config port: cfg_we writes cfg_data into register cfg_index at the clock edge
//   (0 gain_p, 1 gain_i, 2 gain_d, 3 integral limit, 4 duty ceiling, 5 timer top,
//   6 direction); write only while idle.
// sequence:
//   an update item steps through prep, the p, i and d products, accumulate, limit, scale,
//   reciprocal and finish, a restart item from prep straight to scale; the next item is
//   taken only once the sequencer is idle again. the one shared 25x25 multiplier serves the
//   three gain products, the duty-to-period scale and the divide by 100 as a reciprocal.
//   item_stall is high while an item is in work and during reset.
// reset: synchronous rst restores register defaults, clears integral and last error.
// stall: a finished result sits in the output register; while result_stall holds it
//   the sequencer waits in its last step and takes no new item.
module pid_hbridge_duty_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                mode,
  input  logic [phdc_pkg::TEMP_W-1:0]         target_temp,
  input  logic [phdc_pkg::TEMP_W-1:0]         measured_temp,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [phdc_pkg::DUTY_W-1:0]         duty_pct,
  output logic [phdc_pkg::TOP_W-1:0]          heat_compare,
  output logic [phdc_pkg::TOP_W-1:0]          cool_compare,
  output logic                                bridge_enable,
  input  logic                                cfg_we,
  input  logic [phdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phdc_pkg::GAIN_W-1:0]         cfg_data
);
  import phdc_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    busy;
  logic    done;
  logic    start;
  logic    res_ready;

  assign item_stall = busy || rst;
  assign start      = item_valid && !item_stall;
  assign res_ready  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= RST_GAIN_P;
      cfg.gain_i       <= RST_GAIN_I;
      cfg.gain_d       <= RST_GAIN_D;
      cfg.int_limit    <= RST_INT_LIMIT;
      cfg.duty_ceiling <= RST_CEILING;
      cfg.timer_top    <= RST_TOP;
      cfg.direction    <= RST_DIRECTION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:    cfg.gain_p       <= cfg_data;
        REG_GAIN_I:    cfg.gain_i       <= cfg_data;
        REG_GAIN_D:    cfg.gain_d       <= cfg_data;
        REG_INT_LIMIT: cfg.int_limit    <= cfg_data[LIMIT_W-1:0];
        REG_CEILING:   cfg.duty_ceiling <= cfg_data[DUTY_W-1:0];
        REG_TOP:       cfg.timer_top    <= cfg_data[TOP_W-1:0];
        REG_DIRECTION: cfg.direction    <= cfg_data[DIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  phdc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .mode          (mode),
    .target_temp   (target_temp),
    .measured_temp (measured_temp),
    .cfg           (cfg),
    .res_ready     (res_ready),
    .busy          (busy),
    .done          (done),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid  <= 1'b1;
      duty_pct      <= res.duty;
      heat_compare  <= res.heat;
      cool_compare  <= res.cool;
      bridge_enable <= res.enable;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second item taken while first in work");

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    done |=> result_valid)
    else $error("finished result not presented");

endmodule

### bench/tb_pid_hbridge_duty_controller_unit.sv
// testbench for pid_hbridge_duty_controller_unit: directed table, then random register
// settings and control runs, each result checked against a fixed table result or a local predictor
// depends on phdc_pkg and the unit rtl only
`timescale 1ns / 100ps

module tb_pid_hbridge_duty_controller_unit;
  import phdc_pkg::*;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic [DIR_W-1:0] DIR_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1950;
  localparam int NUM_ROWS = 24;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_BURST} stall_style_t;

  typedef struct packed {
    logic                 has_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [GAIN_W-1:0]    val;
    logic                 md;
    logic [TEMP_W-1:0]    tgt;
    logic [TEMP_W-1:0]    meas;
    logic                 fixed;
    result_t              res;
  } row_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic mode;
  logic [TEMP_W-1:0] target_temp;
  logic [TEMP_W-1:0] measured_temp;
  logic result_valid;
  logic result_stall;
  logic [DUTY_W-1:0] duty_pct;
  logic [TOP_W-1:0] heat_compare;
  logic [TOP_W-1:0] cool_compare;
  logic bridge_enable;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  pid_hbridge_duty_controller_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .target_temp(target_temp), .measured_temp(measured_temp),
    .result_valid(result_valid), .result_stall(result_stall),
    .duty_pct(duty_pct), .heat_compare(heat_compare),
    .cool_compare(cool_compare), .bridge_enable(bridge_enable),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register shadow and controller state
  cfg_t settings;
  int integ_sum;
  int prev_err;

  result_t duty_results_due[$];
  int fail_count;
  int items_sent;
  int restarts_sent;
  int phases_run;
  int burst_left;
  bit gaps_on;
  stall_style_t stall_style;
  int stall_cycle;

  row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, REG_GAIN_P, 24'd0, MODE_RESTART, 10'd1023, 10'd1023, 1'b1,
      '{7'd3, 16'd0, 16'd0, 1'b0}},
    '{1'b0, REG_GAIN_P, 24'd0, MODE_UPDATE, 10'd0, 10'd0, 1'b1,
      '{7'd0, 16'd0, 16'd0, 1'b0}},
    '{1'b0, REG_GAIN_P, 24'd0, MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd95, 16'd0, 16'd0, 1'b0}},
    '{1'b0, REG_GAIN_P, 24'd0, MODE_UPDATE, 10'd0, 10'd1023, 1'b1,
      '{7'd0, 16'd0, 16'd0, 1'b0}},
    '{1'b0, REG_GAIN_P, 24'd0, MODE_UPDATE, 10'd512, 10'd500, 1'b0, '0},
    '{1'b1, REG_DIRECTION, 24'(DIR_HEAT), MODE_RESTART, 10'd0, 10'd0, 1'b1,
      '{7'd3, 16'd30, 16'd0, 1'b1}},
    '{1'b0, REG_GAIN_P, 24'd0, MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd95, 16'd950, 16'd0, 1'b1}},
    '{1'b0, REG_GAIN_P, 24'd0, MODE_UPDATE, 10'd300, 10'd290, 1'b0, '0},
    '{1'b1, REG_DIRECTION, 24'(DIR_COOL), MODE_RESTART, 10'd5, 10'd700, 1'b1,
      '{7'd3, 16'd0, 16'd30, 1'b1}},
    '{1'b0, REG_GAIN_P, 24'd0, MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd95, 16'd0, 16'd950, 1'b1}},
    '{1'b1, REG_DIRECTION, 24'(DIR_SPARE), MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd95, 16'd0, 16'd0, 1'b0}},
    '{1'b1, REG_CEILING, 24'd127, MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd100, 16'd0, 16'd0, 1'b0}},
    '{1'b1, REG_DIRECTION, 24'(DIR_HEAT), MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd100, 16'd999, 16'd0, 1'b1}},
    '{1'b1, REG_TOP, 24'd65535, MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd100, 16'd65535, 16'd0, 1'b1}},
    '{1'b1, REG_TOP, 24'd0, MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd100, 16'd0, 16'd0, 1'b1}},
    '{1'b1, REG_CEILING, 24'd0, MODE_UPDATE, 10'd1023, 10'd0, 1'b1,
      '{7'd0, 16'd0, 16'd0, 1'b1}},
    '{1'b1, REG_TOP, 24'(RST_TOP), MODE_RESTART, 10'd1023, 10'd1023, 1'b1,
      '{7'd3, 16'd30, 16'd0, 1'b1}},
    '{1'b1, REG_CEILING, 24'd100, MODE_UPDATE, 10'd20, 10'd10, 1'b0, '0},
    '{1'b1, REG_GAIN_I, 24'd0, MODE_UPDATE, 10'd40, 10'd10, 1'b0, '0},
    '{1'b1, REG_INT_LIMIT, 24'd0, MODE_UPDATE, 10'd45, 10'd10, 1'b0, '0},
    '{1'b1, REG_INT_LIMIT, 24'd65535, MODE_UPDATE, 10'd0, 10'd1023, 1'b0, '0},
    '{1'b1, REG_GAIN_P, 24'hFFFFFF, MODE_UPDATE, 10'd10, 10'd9, 1'b0, '0},
    '{1'b1, REG_GAIN_D, 24'hFFFFFF, MODE_UPDATE, 10'd0, 10'd1023, 1'b0, '0},
    '{1'b1, REG_GAIN_I, 24'hFFFFFF, MODE_UPDATE, 10'd1023, 10'd0, 1'b0, '0}
  };

  always #2 clk = ~clk;

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    case (idx)
      REG_GAIN_P:    settings.gain_p = data;
      REG_GAIN_I:    settings.gain_i = data;
      REG_GAIN_D:    settings.gain_d = data;
      REG_INT_LIMIT: settings.int_limit = data[LIMIT_W-1:0];
      REG_CEILING:   settings.duty_ceiling = data[DUTY_W-1:0];
      REG_TOP:       settings.timer_top = data[TOP_W-1:0];
      REG_DIRECTION: settings.direction = data[DIR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic result_t pid_duty_next(logic md, logic [TEMP_W-1:0] tgt,
                                            logic [TEMP_W-1:0] meas);
    int err;
    int lim;
    int sum;
    int ceil_pct;
    int duty;
    longint acc;
    longint whole;
    longint cmp;
    result_t r;
    if (md == MODE_RESTART) begin
      integ_sum = 0;
      prev_err = 0;
      duty = int'(DUTY_KICK);
    end else begin
      err = int'(tgt) - int'(meas);
      lim = int'(settings.int_limit);
      sum = integ_sum + err;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      integ_sum = sum;
      acc = longint'(settings.gain_p) * err + longint'(settings.gain_i) * sum
          + longint'(settings.gain_d) * (err - prev_err);
      prev_err = err;
      ceil_pct = (settings.duty_ceiling > DUTY_FULL) ? int'(DUTY_FULL)
                                                     : int'(settings.duty_ceiling);
      if (acc < 0) begin
        duty = 0;
      end else begin
        whole = acc >>> FRAC_BITS;
        duty = (whole > ceil_pct) ? ceil_pct : int'(whole);
      end
    end
    cmp = (longint'(settings.timer_top) + 1) * duty / int'(DUTY_FULL);
    if (cmp > longint'(settings.timer_top)) cmp = longint'(settings.timer_top);
    r = '0;
    r.duty = duty[DUTY_W-1:0];
    if (settings.direction == DIR_HEAT) begin
      r.heat = cmp[TOP_W-1:0];
      r.enable = 1'b1;
    end else if (settings.direction == DIR_COOL) begin
      r.cool = cmp[TOP_W-1:0];
      r.enable = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
    logic [GAIN_W-1:0] junk;
    logic [GAIN_W-1:0] val;
    junk = GAIN_W'($urandom);
    case (idx)
      REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: begin
        case ($urandom_range(0, 7))
          0: val = '0;
          1: val = '1;
          2: val = GAIN_W'($urandom);
          3: val = GAIN_W'($urandom_range(0, 1 << 20));
          default: val = GAIN_W'($urandom_range(0, 1 << 18));
        endcase
      end
      REG_INT_LIMIT: begin
        case ($urandom_range(0, 5))
          0: val = {junk[23:16], 16'd0};
          1: val = {junk[23:16], 16'hFFFF};
          2: val = {junk[23:16], 16'($urandom)};
          default: val = {junk[23:16], 16'($urandom_range(0, 3000))};
        endcase
      end
      REG_CEILING: begin
        case ($urandom_range(0, 5))
          0: val = {junk[23:7], 7'd0};
          1: val = {junk[23:7], DUTY_FULL};
          2: val = {junk[23:7], 7'h7F};
          default: val = {junk[23:7], 7'($urandom)};
        endcase
      end
      REG_TOP: begin
        case ($urandom_range(0, 5))
          0: val = {junk[23:16], 16'd0};
          1: val = {junk[23:16], 16'hFFFF};
          2: val = {junk[23:16], RST_TOP};
          default: val = {junk[23:16], 16'($urandom)};
        endcase
      end
      default: val = junk;
    endcase
    return val;
  endfunction

  task automatic pick_temps(output logic [TEMP_W-1:0] tgt, output logic [TEMP_W-1:0] meas);
    int base;
    int other;
    case ($urandom_range(0, 9))
      0: begin
        tgt = TEMP_W'($urandom);
        meas = TEMP_W'($urandom);
      end
      1: begin
        tgt = $urandom_range(0, 1) ? '1 : '0;
        meas = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        base = $urandom_range(0, 1023);
        other = base + $urandom_range(0, 80) - 40;
        if (other < 0) other = 0;
        if (other > 1023) other = 1023;
        tgt = TEMP_W'(base);
        meas = TEMP_W'(other);
      end
    endcase
  endtask

  task automatic settle_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (duty_results_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic push_item(logic md, logic [TEMP_W-1:0] tgt, logic [TEMP_W-1:0] meas,
                           logic fixed, result_t fixed_res);
    int gap;
    result_t r;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    item_valid <= 1'b1;
    mode <= md;
    target_temp <= tgt;
    measured_temp <= meas;
    do @(posedge clk); while (item_stall);
    r = pid_duty_next(md, tgt, meas);
    duty_results_due.push_back(fixed ? fixed_res : r);
    items_sent++;
    if (md == MODE_RESTART) restarts_sent++;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // receiver stall pattern, style picked anew whenever the low byte of stall_cycle is zero
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_cycle <= 0;
      stall_style <= STALL_NONE;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle[7:0] == 8'd0) stall_style <= stall_style_t'($urandom_range(0, 3));
      case (stall_style)
        STALL_RANDOM:   result_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: result_stall <= (stall_cycle[2:0] < 3'd3);
        STALL_BURST:    result_stall <= (stall_cycle[5:3] == 3'd0);
        default:        result_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (duty_results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, duty %0d", $time, duty_pct);
        fail_count++;
      end else begin
        want = duty_results_due.pop_front();
        check_field("duty_pct", want.duty, duty_pct);
        check_field("heat_compare", want.heat, heat_compare);
        check_field("cool_compare", want.cool, cool_compare);
        check_field("bridge_enable", want.enable, bridge_enable);
      end
    end
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [TEMP_W-1:0] tgt;
    logic [TEMP_W-1:0] meas;
    logic md;
    int batch;
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    mode = 1'b0;
    target_temp = '0;
    measured_temp = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    items_sent = 0;
    restarts_sent = 0;
    phases_run = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    settings = '{RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_INT_LIMIT,
                 RST_CEILING, RST_TOP, RST_DIRECTION};
    integ_sum = 0;
    prev_err = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_cfg) begin
        settle_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
        cfg_we <= 1'b0;
      end
      push_item(directed_rows[i].md, directed_rows[i].tgt, directed_rows[i].meas,
                directed_rows[i].fixed, directed_rows[i].res);
    end

    while (items_sent < RANDOM_ITEMS) begin
      settle_idle();
      for (int r = 0; r <= int'(REG_DIRECTION); r++)
        write_reg(CFG_IDX_W'(r), pick_reg_value(CFG_IDX_W'(r)));
      cfg_we <= 1'b0;
      phases_run++;
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      batch = $urandom_range(40, 120);
      if (batch > RANDOM_ITEMS - items_sent) batch = RANDOM_ITEMS - items_sent;
      repeat (batch) begin
        md = ($urandom_range(0, 11) == 0) ? MODE_RESTART : MODE_UPDATE;
        pick_temps(tgt, meas);
        push_item(md, tgt, meas, 1'b0, '0);
      end
    end

    settle_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d item beats, %0d of them restarts", items_sent, restarts_sent);
    $display("random part ran %0d register settings after the directed table", phases_run);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### pid_hbridge_duty_controller_unit.f
sv/phdc_pkg.sv
sv/phdc_mul.sv
sv/phdc_core.sv
sv/pid_hbridge_duty_controller_unit.sv
bench/tb_pid_hbridge_duty_controller_unit.sv
